// ===== rtl/brc_pkg.sv =====
// Shared types, constants and command/status structs of the button and panel
// refresh controller. Depends on nothing; every other rtl file uses it.
package brc_pkg;

    // Field and register widths
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int ACTION_W        = 3;
    localparam int OP_W            = 2;
    localparam int TIME_W          = 32;
    localparam int LEVEL_W         = 4;
    localparam int RUN_W           = 16;
    localparam int SCRIPT_W        = 8;
    localparam int MOD_IDX_W       = RUN_W + 1;
    localparam int DEGHOST_W       = 8;
    localparam int DEBOUNCE_W      = 16;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int S_TDATA_W       = 56;
    localparam int S_TUSER_W       = 8;
    localparam int M_TDATA_W       = 8;

    // Register reset values
    localparam logic [DEGHOST_W-1:0]  DEGHOST_RST  = 8'd24;
    localparam logic [TIME_W-1:0]     AUTO_RST     = 32'd77000;
    localparam logic [TIME_W-1:0]     LONG_RST     = 32'd5000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd40;
    localparam logic [SCRIPT_W-1:0]   COUNT_RST    = 8'd1;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_DEGHOST  = 3'd0;
    localparam logic [2:0] REG_AUTO     = 3'd1;
    localparam logic [2:0] REG_LONG     = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE = 3'd3;
    localparam logic [2:0] REG_COUNT    = 3'd4;

    // Corner button positions
    localparam int BTN_TOP_LEFT     = 0;
    localparam int BTN_TOP_RIGHT    = 1;
    localparam int BTN_BOTTOM_LEFT  = 2;
    localparam int BTN_BOTTOM_RIGHT = 3;
    localparam int BTN_LEVEL_COUNT  = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_IND_ON  = 3'd0,
        ACT_IND_OFF = 3'd1,
        ACT_CLEAR   = 3'd2,
        ACT_TITLE   = 3'd3,
        ACT_RENDER  = 3'd4
    } action_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_NEXT  = 2'd2,
        OP_RUN   = 2'd3
    } op_t;

    // Source of the script index handed to the wrap unit
    typedef enum logic [2:0] {
        IDX_ZERO    = 3'd0,
        IDX_CUR_INC = 3'd1,
        IDX_RUN     = 3'd2,
        IDX_CUR     = 3'd3,
        IDX_CUR_DEC = 3'd4
    } idx_sel_t;

    typedef struct packed {
        logic [DEGHOST_W-1:0]  deghost;
        logic [TIME_W-1:0]     auto_ms;
        logic [TIME_W-1:0]     long_ms;
        logic [DEBOUNCE_W-1:0] debounce;
        logic [SCRIPT_W-1:0]   count;
    } cfg_t;

    typedef struct packed {
        logic     load_item;
        logic     mod_start;
        idx_sel_t idx_sel;
        logic     panel_upd;
        logic     set_last_time;
        logic     force_full;
        logic     emit;
        action_t  action;
        logic     set_held;
        logic     clr_held;
        logic     btn_rst;
        logic     btn_inc;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_free;
        logic mod_done;
        logic auto_due;
        logic press;
        logic long_due;
        logic rel;
        logic debounced;
        logic is_tr;
        logic is_bl;
        logic is_br;
        logic btn_last;
    } dp_stat_t;

endpackage

// ===== rtl/brc_wrap.sv =====
// Iterative script index wrap: mathematical modulo of a signed index by the
// script count, one remainder bit per cycle. Depends on brc_pkg.
module brc_wrap (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [brc_pkg::MOD_IDX_W-1:0] idx,
    input  logic        [brc_pkg::SCRIPT_W-1:0]  count,
    output logic                                 done,
    output logic        [brc_pkg::SCRIPT_W-1:0]  result
);
    localparam int MAG_W = brc_pkg::MOD_IDX_W - 1;
    localparam int CNT_W = $clog2(MAG_W);
    localparam int SW    = brc_pkg::SCRIPT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     n_reg, n_next;
    logic              neg_reg, neg_next;
    logic [SW-1:0]     res_reg, res_next;

    logic [SW-1:0]              n_in;
    logic [brc_pkg::MOD_IDX_W-1:0] neg_idx;
    logic                       fast;
    logic [SW:0]                trial;
    logic [SW-1:0]              rem_step;

    // Zero scripts counts as one
    assign n_in    = (count == '0) ? SW'(1) : count;
    assign neg_idx = -idx;
    assign fast    = !idx[brc_pkg::MOD_IDX_W-1] &&
                     (idx[MAG_W-1:0] < {{(MAG_W-SW){1'b0}}, n_in});

    // One restoring remainder step
    assign trial    = {rem_reg, mag_reg[MAG_W-1]};
    assign rem_step = (trial >= {1'b0, n_reg}) ? SW'(trial - {1'b0, n_reg}) : trial[SW-1:0];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        n_next    = n_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (start) begin
            n_next   = n_in;
            neg_next = idx[brc_pkg::MOD_IDX_W-1];
            mag_next = idx[brc_pkg::MOD_IDX_W-1] ? neg_idx[MAG_W-1:0] : idx[MAG_W-1:0];
            rem_next = '0;
            cnt_next = '0;
            if (fast) begin
                res_next  = idx[SW-1:0];
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = rem_step;
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // Fold a negative remainder into range
                res_next  = (neg_reg && rem_step != '0) ? SW'(n_reg - rem_step) : rem_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        n_reg   <= n_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

// ===== rtl/brc_datapath.sv =====
// Datapath: item registers, script and refresh state, button timing, the
// wrap unit and the output register. Depends on brc_pkg and brc_wrap.
module brc_datapath #(
    parameter int NUM_BUTTONS = brc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  brc_pkg::cfg_t                   cfg,
    input  brc_pkg::dp_cmd_t                cmd,
    output brc_pkg::dp_stat_t               stat,
    input  logic [brc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic [brc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [brc_pkg::M_TDATA_W-1:0]   m_tdata
);
    localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int TW    = brc_pkg::TIME_W;
    localparam int SW    = brc_pkg::SCRIPT_W;
    localparam int IW    = brc_pkg::MOD_IDX_W;

    // Item registers
    brc_pkg::op_t                   op_reg;
    logic [TW-1:0]                  now_reg;
    logic [brc_pkg::LEVEL_W-1:0]    levels_reg;
    logic [brc_pkg::RUN_W-1:0]      run_reg;

    // Controller state kept here
    logic [SW-1:0]                  cur_reg;
    logic [brc_pkg::DEGHOST_W-1:0]  usf_reg, usf_next;
    logic [TW-1:0]                  last_reg;
    logic [NUM_BUTTONS-1:0]         held_reg;
    logic [TW-1:0]                  press_reg [NUM_BUTTONS];
    logic [BTN_W-1:0]               btn_reg;
    logic                           out_valid_reg;
    brc_pkg::action_t               out_action_reg;

    logic [NUM_BUTTONS-1:0]         lvl_ext;
    logic signed [IW-1:0]           mod_idx;
    logic                           mod_done;
    logic [SW-1:0]                  mod_res;
    logic [TW-1:0]                  held_time;
    logic                           down;
    logic                           held;
    logic                           is_tl;

    // Buttons past the fourth never read as pressed
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lvl
        if (g < brc_pkg::BTN_LEVEL_COUNT) begin : g_on
            assign lvl_ext[g] = levels_reg[g];
        end else begin : g_off
            assign lvl_ext[g] = 1'b0;
        end
    end

    // Pick the index to wrap
    always_comb begin
        unique case (cmd.idx_sel)
            brc_pkg::IDX_ZERO:    mod_idx = '0;
            brc_pkg::IDX_CUR_INC: mod_idx = $signed({{(IW-SW){1'b0}}, cur_reg}) + IW'(1);
            brc_pkg::IDX_RUN:     mod_idx = $signed({run_reg[brc_pkg::RUN_W-1], run_reg});
            brc_pkg::IDX_CUR:     mod_idx = $signed({{(IW-SW){1'b0}}, cur_reg});
            brc_pkg::IDX_CUR_DEC: mod_idx = $signed({{(IW-SW){1'b0}}, cur_reg}) - IW'(1);
            default:              mod_idx = '0;
        endcase
    end

    brc_wrap u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .idx     (mod_idx),
        .count   (cfg.count),
        .done    (mod_done),
        .result  (mod_res)
    );

    // Current button view
    assign down      = lvl_ext[btn_reg];
    assign held      = held_reg[btn_reg];
    assign held_time = now_reg - press_reg[btn_reg];
    assign is_tl     = 32'(btn_reg) == brc_pkg::BTN_TOP_LEFT;

    // Refresh kind of one panel update
    always_comb begin
        usf_next = usf_reg;
        if (cmd.force_full) begin
            usf_next = cfg.deghost;
        end else if (cmd.panel_upd) begin
            usf_next = (usf_reg >= cfg.deghost) ? '0 : usf_reg + 8'd1;
        end
    end

    always_comb begin
        stat.op        = op_reg;
        stat.out_free  = !out_valid_reg || m_tready;
        stat.mod_done  = mod_done;
        stat.auto_due  = (now_reg - last_reg) >= cfg.auto_ms;
        stat.press     = down && !held;
        stat.long_due  = down && held && is_tl && (held_time >= cfg.long_ms);
        stat.rel       = !down && held;
        stat.debounced = held_time >= {{(TW-brc_pkg::DEBOUNCE_W){1'b0}}, cfg.debounce};
        stat.is_tr     = 32'(btn_reg) == brc_pkg::BTN_TOP_RIGHT;
        stat.is_bl     = 32'(btn_reg) == brc_pkg::BTN_BOTTOM_LEFT;
        stat.is_br     = 32'(btn_reg) == brc_pkg::BTN_BOTTOM_RIGHT;
        stat.btn_last  = 32'(btn_reg) == NUM_BUTTONS - 1;
    end

    // Capture the accepted beat, the press time and the output action
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg     <= brc_pkg::op_t'(s_tuser[brc_pkg::OP_W-1:0]);
            now_reg    <= s_tdata[TW-1:0];
            levels_reg <= s_tdata[TW +: brc_pkg::LEVEL_W];
            run_reg    <= s_tdata[TW + brc_pkg::LEVEL_W +: brc_pkg::RUN_W];
        end
        if (cmd.set_held) begin
            press_reg[btn_reg] <= now_reg;
        end
        if (cmd.emit) begin
            out_action_reg <= cmd.action;
        end
    end

    // Script, refresh, button and output valid state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            usf_reg       <= brc_pkg::DEGHOST_RST;
            last_reg      <= '0;
            held_reg      <= '0;
            btn_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mod_done) begin
                cur_reg <= mod_res;
            end
            usf_reg <= usf_next;
            if (cmd.set_last_time) begin
                last_reg <= now_reg;
            end
            if (cmd.set_held) begin
                held_reg[btn_reg] <= 1'b1;
            end else if (cmd.clr_held) begin
                held_reg[btn_reg] <= 1'b0;
            end
            if (cmd.btn_rst) begin
                btn_reg <= '0;
            end else if (cmd.btn_inc) begin
                btn_reg <= btn_reg + BTN_W'(1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(brc_pkg::M_TDATA_W-brc_pkg::ACTION_W){1'b0}}, out_action_reg};
endmodule

// ===== rtl/brc_ctrl.sv =====
// Controller state machine: walks one item through op, auto re-render and
// the button scan, issuing datapath commands. Depends on brc_pkg.
module brc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  brc_pkg::dp_stat_t  stat,
    output brc_pkg::dp_cmd_t   cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_OP     = 9'b000000010,
        S_MOD    = 9'b000000100,
        S_TITLE  = 9'b000001000,
        S_RENDER = 9'b000010000,
        S_AUTO   = 9'b000100000,
        S_BTN    = 9'b001000000,
        S_NEXT   = 9'b010000000,
        S_SPARE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   ann_reg, ann_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        ann_next   = ann_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_OP;
                end
            end
            // Select and announce a script for start, next and run
            S_OP: begin
                ann_next = 1'b1;
                ret_next = S_AUTO;
                unique case (stat.op)
                    brc_pkg::OP_TICK:  state_next = S_AUTO;
                    brc_pkg::OP_START: begin
                        cmd.mod_start = 1'b1;
                        cmd.idx_sel   = brc_pkg::IDX_ZERO;
                        state_next    = S_MOD;
                    end
                    brc_pkg::OP_NEXT: begin
                        cmd.mod_start = 1'b1;
                        cmd.idx_sel   = brc_pkg::IDX_CUR_INC;
                        state_next    = S_MOD;
                    end
                    brc_pkg::OP_RUN: begin
                        cmd.mod_start = 1'b1;
                        cmd.idx_sel   = brc_pkg::IDX_RUN;
                        state_next    = S_MOD;
                    end
                    default: state_next = S_AUTO;
                endcase
            end
            // Wait for the wrapped index
            S_MOD: begin
                if (stat.mod_done) begin
                    state_next = ann_reg ? S_TITLE : S_RENDER;
                end
            end
            S_TITLE: begin
                if (stat.out_free) begin
                    cmd.panel_upd = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.action    = brc_pkg::ACT_TITLE;
                    state_next    = S_RENDER;
                end
            end
            S_RENDER: begin
                if (stat.out_free) begin
                    cmd.panel_upd     = 1'b1;
                    cmd.set_last_time = 1'b1;
                    cmd.emit          = 1'b1;
                    cmd.action        = brc_pkg::ACT_RENDER;
                    state_next        = ret_reg;
                end
            end
            // Idle timeout re-renders the current script
            S_AUTO: begin
                cmd.btn_rst = 1'b1;
                if (stat.auto_due) begin
                    cmd.mod_start = 1'b1;
                    cmd.idx_sel   = brc_pkg::IDX_CUR;
                    ann_next      = 1'b0;
                    ret_next      = S_BTN;
                    state_next    = S_MOD;
                end else begin
                    state_next = S_BTN;
                end
            end
            // Handle one button; hold while the output register is full
            S_BTN: begin
                priority if (stat.press) begin
                    if (stat.out_free) begin
                        cmd.set_held = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.action   = brc_pkg::ACT_IND_ON;
                        state_next   = S_NEXT;
                    end
                end else if (stat.long_due) begin
                    if (stat.out_free) begin
                        cmd.force_full = 1'b1;
                        cmd.clr_held   = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.action     = brc_pkg::ACT_CLEAR;
                        cmd.mod_start  = 1'b1;
                        cmd.idx_sel    = brc_pkg::IDX_CUR;
                        ann_next       = 1'b0;
                        ret_next       = S_NEXT;
                        state_next     = S_MOD;
                    end
                end else if (stat.rel) begin
                    if (stat.out_free) begin
                        cmd.clr_held = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.action   = brc_pkg::ACT_IND_OFF;
                        ret_next     = S_NEXT;
                        priority if (stat.debounced && stat.is_tr) begin
                            cmd.mod_start = 1'b1;
                            cmd.idx_sel   = brc_pkg::IDX_CUR_DEC;
                            ann_next      = 1'b1;
                            state_next    = S_MOD;
                        end else if (stat.debounced && stat.is_br) begin
                            cmd.mod_start = 1'b1;
                            cmd.idx_sel   = brc_pkg::IDX_CUR_INC;
                            ann_next      = 1'b1;
                            state_next    = S_MOD;
                        end else if (stat.debounced && stat.is_bl) begin
                            cmd.mod_start = 1'b1;
                            cmd.idx_sel   = brc_pkg::IDX_CUR;
                            ann_next      = 1'b0;
                            state_next    = S_MOD;
                        end else begin
                            state_next = S_NEXT;
                        end
                    end
                end else begin
                    state_next = S_NEXT;
                end
            end
            // Advance the scan or finish the item
            S_NEXT: begin
                if (stat.btn_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.btn_inc = 1'b1;
                    state_next  = S_BTN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_AUTO;
            ann_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ann_reg   <= ann_next;
        end
    end
endmodule

// ===== rtl/button_and_panel_refresh_controller_core.sv =====
// One item at a time: a new beat is accepted only once the previous item is finished.
// Each script selection runs through the wrap unit (one remainder bit per cycle,
// 16 steps unless the index is in range) and, when announced, a title beat. Results
// stall behind an unread output beat. Reset: synchronous, active low; registers
// return to defaults and state clears at once, no clearing pass.
module button_and_panel_refresh_controller_core #(
    parameter int NUM_BUTTONS = brc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: now_ms [31:0], button_levels [35:32], run_index [51:36]
    input  logic [brc_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: op [1:0]
    input  logic [brc_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: action [2:0]
    output logic [brc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [brc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    brc_pkg::cfg_t     cfg_reg;
    brc_pkg::dp_cmd_t  dp_cmd;
    brc_pkg::dp_stat_t dp_stat;
    logic [2:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[brc_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deghost  <= brc_pkg::DEGHOST_RST;
            cfg_reg.auto_ms  <= brc_pkg::AUTO_RST;
            cfg_reg.long_ms  <= brc_pkg::LONG_RST;
            cfg_reg.debounce <= brc_pkg::DEBOUNCE_RST;
            cfg_reg.count    <= brc_pkg::COUNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                brc_pkg::REG_DEGHOST:  cfg_reg.deghost  <= pwdata[brc_pkg::DEGHOST_W-1:0];
                brc_pkg::REG_AUTO:     cfg_reg.auto_ms  <= pwdata[brc_pkg::TIME_W-1:0];
                brc_pkg::REG_LONG:     cfg_reg.long_ms  <= pwdata[brc_pkg::TIME_W-1:0];
                brc_pkg::REG_DEBOUNCE: cfg_reg.debounce <= pwdata[brc_pkg::DEBOUNCE_W-1:0];
                brc_pkg::REG_COUNT:    cfg_reg.count    <= pwdata[brc_pkg::SCRIPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            brc_pkg::REG_DEGHOST:  prdata = 32'(cfg_reg.deghost);
            brc_pkg::REG_AUTO:     prdata = cfg_reg.auto_ms;
            brc_pkg::REG_LONG:     prdata = cfg_reg.long_ms;
            brc_pkg::REG_DEBOUNCE: prdata = 32'(cfg_reg.debounce);
            brc_pkg::REG_COUNT:    prdata = 32'(cfg_reg.count);
            default:               prdata = '0;
        endcase
    end

    brc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    brc_datapath #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // An accepted beat keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a beat");

    // A result is only loaded when the output register can take it
    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> dp_stat.out_free)
        else $error("result loaded over a pending output beat");

    // Output beats carry a defined action code
    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= brc_pkg::ACT_RENDER) && (m_tdata[7:3] == 5'd0))
        else $error("undefined action on output");
endmodule

// ===== bench/tb_button_and_panel_refresh_controller_core.sv =====
// Self-checking bench for button_and_panel_refresh_controller_core: a directed table
// and random button/script traffic, checked beat by beat against fixed or predicted actions.
// Depends on brc_pkg and the core RTL only.
module tb_button_and_panel_refresh_controller_core;
    import brc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int DRAIN_CYCLES  = 48;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 27;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // One row of stimulus: either a register write or an input beat
    typedef struct {
        bit           is_cfg;
        logic [2:0]   reg_idx;
        logic [31:0]  value;
        op_t          op;
        logic [31:0]  now;
        logic [3:0]   levels;
        logic [15:0]  run_idx;
        int           n_fixed;   // -1: expectations come from the predictor
        action_t      fixed[2];
    } stim_row_t;

    stim_row_t stim_table[$];
    action_t   pending_actions[$];
    action_t   step_actions[$];
    int        err_count;
    bit        send_burst;
    bit        take_burst;

    // Predictor copy of the registers (the refresh kind is not visible on the result
    // port, so the de-ghost interval and the full-refresh counter are not modeled)
    logic [TIME_W-1:0]     cfg_auto;
    logic [TIME_W-1:0]     cfg_long;
    logic [DEBOUNCE_W-1:0] cfg_debounce;
    logic [SCRIPT_W-1:0]   cfg_count;

    // Predictor state
    logic [SCRIPT_W-1:0]   pm_script;
    logic [TIME_W-1:0]     pm_last_render;
    logic                  pm_held[BTN_LEVEL_COUNT];
    logic [TIME_W-1:0]     pm_press[BTN_LEVEL_COUNT];

    button_and_panel_refresh_controller_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("mismatch: %s", what);
    endtask

    // Wrap an index into the script range, announce it if asked, then render it
    task automatic select_script(input int idx, input bit announce, input logic [31:0] now);
        int n;
        int r;
        n = (cfg_count == 0) ? 1 : int'(cfg_count);
        r = idx % n;
        if (r < 0) r += n;
        pm_script = SCRIPT_W'(r);
        if (announce) step_actions.push_back(ACT_TITLE);
        pm_last_render = now;
        step_actions.push_back(ACT_RENDER);
    endtask

    // Work out the panel actions of one input beat, in emission order
    task automatic predict_panel_step(input op_t op, input logic [31:0] now,
                                      input logic [3:0] levels, input logic [15:0] run_idx);
        logic [31:0] held_ms;
        bit          down;
        int          i;
        step_actions.delete();
        case (op)
            OP_START: select_script(0, 1'b1, now);
            OP_NEXT:  select_script(int'(pm_script) + 1, 1'b1, now);
            OP_RUN:   select_script(int'($signed(run_idx)), 1'b1, now);
            default: ;
        endcase
        if (now - pm_last_render >= cfg_auto) select_script(int'(pm_script), 1'b0, now);
        for (i = 0; i < BTN_LEVEL_COUNT; i++) begin
            down = levels[i];
            if (down && !pm_held[i]) begin
                pm_held[i]  = 1'b1;
                pm_press[i] = now;
                step_actions.push_back(ACT_IND_ON);
            end else if (down && pm_held[i] && i == BTN_TOP_LEFT &&
                         now - pm_press[i] >= cfg_long) begin
                // long press: clear and re-render, button counts as released
                step_actions.push_back(ACT_CLEAR);
                select_script(int'(pm_script), 1'b0, now);
                pm_held[i] = 1'b0;
            end else if (!down && pm_held[i]) begin
                pm_held[i] = 1'b0;
                step_actions.push_back(ACT_IND_OFF);
                held_ms = now - pm_press[i];
                if (held_ms >= TIME_W'(cfg_debounce)) begin
                    if (i == BTN_TOP_RIGHT) begin
                        select_script(int'(pm_script) - 1, 1'b1, now);
                    end else if (i == BTN_BOTTOM_RIGHT) begin
                        select_script(int'(pm_script) + 1, 1'b1, now);
                    end else if (i == BTN_BOTTOM_LEFT) begin
                        select_script(int'(pm_script), 1'b0, now);
                    end
                end
            end
        end
    endtask

    task automatic tbl_item(input op_t op, input logic [31:0] now, input logic [3:0] levels,
                            input logic [15:0] run_idx, input int n_fixed,
                            input action_t a0 = ACT_IND_ON, input action_t a1 = ACT_IND_ON);
        stim_row_t row;
        row.is_cfg   = 1'b0;
        row.reg_idx  = REG_DEGHOST;
        row.value    = '0;
        row.op       = op;
        row.now      = now;
        row.levels   = levels;
        row.run_idx  = run_idx;
        row.n_fixed  = n_fixed;
        row.fixed[0] = a0;
        row.fixed[1] = a1;
        stim_table.push_back(row);
    endtask

    task automatic tbl_cfg(input logic [2:0] idx, input logic [31:0] value);
        stim_row_t row;
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.value    = value;
        row.op       = OP_TICK;
        row.now      = '0;
        row.levels   = '0;
        row.run_idx  = '0;
        row.n_fixed  = -1;
        row.fixed[0] = ACT_IND_ON;
        row.fixed[1] = ACT_IND_ON;
        stim_table.push_back(row);
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_AUTO:     cfg_auto     = value;
            REG_LONG:     cfg_long     = value;
            REG_DEBOUNCE: cfg_debounce = value[DEBOUNCE_W-1:0];
            REG_COUNT:    cfg_count    = value[SCRIPT_W-1:0];
            default: ;
        endcase
    endtask

    // Drive one input beat, then queue what it should produce
    task automatic send_beat(input stim_row_t row);
        int gap;
        int k;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({row.run_idx, row.levels, row.now});
        s_tuser  <= S_TUSER_W'(row.op);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_panel_step(row.op, row.now, row.levels, row.run_idx);
        if (row.n_fixed < 0) begin
            foreach (step_actions[k]) pending_actions.push_back(step_actions[k]);
        end else begin
            for (k = 0; k < row.n_fixed; k++) pending_actions.push_back(row.fixed[k]);
        end
        if ($urandom_range(0, 11) == 0) send_burst = ~send_burst;
    endtask

    // Result side: random stalls, compare every beat with the oldest expectation
    initial begin
        int      gap;
        action_t want;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = take_burst ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_actions.size() == 0) begin
                flag_mismatch($sformatf("result beat action %0d with none pending",
                                        m_tdata[ACTION_W-1:0]));
            end else begin
                want = pending_actions.pop_front();
                if (m_tdata[ACTION_W-1:0] !== want)
                    flag_mismatch($sformatf("action %0d, expected %0d",
                                            m_tdata[ACTION_W-1:0], want));
            end
            if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial begin
        stim_row_t   row;
        logic [31:0] clock_ms;
        logic [3:0]  btn_state;
        int          roll;
        int          bit_idx;
        int          p;
        int          n;

        s_tdata    = '0;
        s_tuser    = '0;
        s_tvalid   = 1'b0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        aresetn    = 1'b0;
        err_count  = 0;
        send_burst = 1'b0;
        take_burst = 1'b0;

        // Predictor at its reset state
        cfg_auto       = AUTO_RST;
        cfg_long       = LONG_RST;
        cfg_debounce   = DEBOUNCE_RST;
        cfg_count      = COUNT_RST;
        pm_script      = '0;
        pm_last_render = '0;
        for (n = 0; n < BTN_LEVEL_COUNT; n++) begin
            pm_held[n]  = 1'b0;
            pm_press[n] = '0;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults after reset: press/release, short top-left release, long press
        tbl_item(OP_TICK,  32'd0,    4'h0, 16'h0000, 0);
        tbl_item(OP_START, 32'd100,  4'h0, 16'h0000, 2, ACT_TITLE, ACT_RENDER);
        tbl_item(OP_TICK,  32'd200,  4'h1, 16'h0000, 1, ACT_IND_ON);
        tbl_item(OP_TICK,  32'd210,  4'h0, 16'h0000, 1, ACT_IND_OFF);
        tbl_item(OP_TICK,  32'd300,  4'h2, 16'h0000, 1, ACT_IND_ON);
        tbl_item(OP_TICK,  32'd400,  4'h0, 16'h0000, -1);
        tbl_item(OP_TICK,  32'd500,  4'h1, 16'h0000, 1, ACT_IND_ON);
        tbl_item(OP_TICK,  32'd5500, 4'h1, 16'h0000, 2, ACT_CLEAR, ACT_RENDER);
        tbl_item(OP_TICK,  32'd5600, 4'h1, 16'h0000, 1, ACT_IND_ON);
        tbl_item(OP_TICK,  32'd5700, 4'h0, 16'h0000, 1, ACT_IND_OFF);
        tbl_item(OP_TICK,  32'd5800, 4'hC, 16'h0000, -1);
        tbl_item(OP_TICK,  32'd5900, 4'h0, 16'h0000, -1);
        tbl_item(OP_NEXT,  32'd6000, 4'h0, 16'h0000, -1);
        tbl_item(OP_RUN,   32'd6100, 4'h0, 16'h8000, -1);
        // Upper extremes, zero de-ghost interval, zero debounce
        tbl_cfg(REG_DEGHOST,  32'd0);
        tbl_cfg(REG_COUNT,    32'd255);
        tbl_cfg(REG_DEBOUNCE, 32'd0);
        tbl_cfg(REG_LONG,     32'hFFFF_FFFF);
        tbl_cfg(REG_AUTO,     32'hFFFF_FFFF);
        tbl_item(OP_RUN,   32'd7000, 4'h0, 16'h7FFF, -1);
        tbl_item(OP_RUN,   32'd7010, 4'h0, 16'hFFFF, -1);
        tbl_item(OP_TICK,  32'd7020, 4'hF, 16'h0000, -1);
        tbl_item(OP_TICK,  32'd7020, 4'h0, 16'h0000, -1);
        // Zero script count, zero timeouts, time wrap
        tbl_cfg(REG_COUNT,    32'd0);
        tbl_cfg(REG_AUTO,     32'd0);
        tbl_cfg(REG_LONG,     32'd0);
        tbl_cfg(REG_DEBOUNCE, 32'd65535);
        tbl_cfg(REG_DEGHOST,  32'd255);
        tbl_item(OP_RUN,   32'hFFFF_FFF0, 4'h0, 16'h1234, -1);
        tbl_item(OP_TICK,  32'h0000_0010, 4'h1, 16'h0000, -1);
        tbl_item(OP_TICK,  32'h0000_0020, 4'h1, 16'h0000, -1);
        tbl_item(OP_NEXT,  32'hFFFF_FFFF, 4'hF, 16'h5555, -1);
        tbl_item(OP_TICK,  32'h8000_0000, 4'h0, 16'hAAAA, -1);
        tbl_item(OP_RUN,   32'h7FFF_FFFF, 4'h0, 16'h0000, -1);

        foreach (stim_table[n]) begin
            if (stim_table[n].is_cfg) write_reg(stim_table[n].reg_idx, stim_table[n].value);
            else send_beat(stim_table[n]);
        end

        // Random phases: one register setting each, then button and script traffic
        clock_ms  = 32'd1000;
        btn_state = 4'h0;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                write_reg(REG_DEGHOST,  32'd1);
                write_reg(REG_AUTO,     32'd1500);
                write_reg(REG_LONG,     32'd800);
                write_reg(REG_DEBOUNCE, 32'd0);
                write_reg(REG_COUNT,    32'd3);
            end else if (p == 1) begin
                write_reg(REG_DEGHOST,  32'd255);
                write_reg(REG_AUTO,     32'hFFFF_FFFF);
                write_reg(REG_LONG,     32'hFFFF_FFFF);
                write_reg(REG_DEBOUNCE, 32'd65535);
                write_reg(REG_COUNT,    32'd255);
            end else begin
                write_reg(REG_DEGHOST, $urandom_range(0, 255));
                roll = $urandom_range(0, 3);
                write_reg(REG_AUTO, (roll == 0) ? 32'd0 :
                                    (roll == 3) ? $urandom : $urandom_range(100, 3000));
                roll = $urandom_range(0, 3);
                write_reg(REG_LONG, (roll == 0) ? 32'd0 :
                                    (roll == 3) ? $urandom : $urandom_range(50, 2000));
                roll = $urandom_range(0, 3);
                write_reg(REG_DEBOUNCE, (roll == 0) ? 32'd0 :
                                        (roll == 3) ? $urandom_range(0, 65535) :
                                                      $urandom_range(0, 200));
                roll = $urandom_range(0, 3);
                write_reg(REG_COUNT, (roll == 0) ? 32'd0 :
                                     (roll == 3) ? $urandom_range(1, 255) :
                                                   $urandom_range(1, 8));
            end
            // Start some phases just below the 32-bit time wrap
            if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Advance time mostly in small steps
                roll = $urandom_range(0, 99);
                if (roll < 88) clock_ms = clock_ms + $urandom_range(0, 300);
                else if (roll < 96) clock_ms = clock_ms + $urandom_range(0, 100000);
                else clock_ms = $urandom;
                // Evolve the button levels one corner at a time, with some noise
                roll = $urandom_range(0, 99);
                if (roll < 30) begin
                    bit_idx = $urandom_range(0, BTN_LEVEL_COUNT - 1);
                    btn_state[bit_idx] = ~btn_state[bit_idx];
                end else if (roll < 35) begin
                    btn_state = 4'($urandom_range(0, 15));
                end
                row.is_cfg  = 1'b0;
                row.reg_idx = REG_DEGHOST;
                row.value   = '0;
                row.now     = clock_ms;
                row.levels  = btn_state;
                row.n_fixed = -1;
                row.op      = ($urandom_range(0, 99) < 65) ? OP_TICK :
                              op_t'($urandom_range(1, 3));
                roll = $urandom_range(0, 3);
                if (roll < 2) row.run_idx = 16'($urandom_range(0, 20));
                else if (roll == 2) row.run_idx = -16'($urandom_range(1, 20));
                else row.run_idx = 16'($urandom_range(0, 65535));
                row.fixed[0] = ACT_IND_ON;
                row.fixed[1] = ACT_IND_ON;
                send_beat(row);
            end
        end

        // Drain: every expected beat in, then let the block settle
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("[button_and_panel_refresh_controller_core] OK");
        end else begin
            $display("[button_and_panel_refresh_controller_core] ERROR");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #(2 * CLK_HALF * 1000000);
        $display("[button_and_panel_refresh_controller_core] ERROR");
        $finish;
    end

endmodule

// ===== button_and_panel_refresh_controller_core.f =====
rtl/brc_pkg.sv
rtl/brc_wrap.sv
rtl/brc_datapath.sv
rtl/brc_ctrl.sv
rtl/button_and_panel_refresh_controller_core.sv
bench/tb_button_and_panel_refresh_controller_core.sv
